// ===== rtl/sfe_pkg.sv =====
package sfe_pkg;

  localparam int ByteW      = 8;
  localparam int LenW       = 12;
  localparam int TotalW     = 16;
  localparam int MaxPayload = 2048;
  localparam int MaxBurst   = 9;
  localparam int CntW       = $clog2(MaxBurst + 1);

  localparam logic [ByteW-1:0]  StxByte  = 8'h7E;
  localparam logic [ByteW-1:0]  CrByte   = 8'h0D;
  localparam logic [ByteW-1:0]  LfByte   = 8'h0A;
  localparam logic [ByteW-1:0]  FcReset  = 8'h04;
  localparam logic [TotalW-1:0] LenExtra = 16'd3;

  localparam logic [CntW-1:0] CntMid      = CntW'(1);
  localparam logic [CntW-1:0] CntMidTail  = CntW'(4);
  localparam logic [CntW-1:0] CntHead     = CntW'(6);
  localparam logic [CntW-1:0] CntHeadTail = CntW'(9);

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [LenW-1:0]  len_t;

  typedef struct packed {
    logic [MaxBurst-1:0][ByteW-1:0] data;
    logic [CntW-1:0]                cnt;
    logic                           tail;
  } burst_t;

endpackage

// ===== rtl/sfe_in_if.sv =====
interface sfe_in_if
  import sfe_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t payload_byte;
  len_t  payload_len;

  modport source (output valid, output payload_byte, output payload_len, input ready);
  modport sink (input valid, input payload_byte, input payload_len, output ready);
endinterface

// ===== rtl/sfe_out_if.sv =====
interface sfe_out_if
  import sfe_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  frame_done;
  logic  last_of_run;

  modport source (output valid, output out_byte, output frame_done, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input frame_done, input last_of_run,
                output ready);
endinterface

// ===== rtl/sfe_core.sv =====
module sfe_core
  import sfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  byte_t      cfg_wdata,
  sfe_in_if.sink     in_if,
  input  logic       room,
  output logic       load,
  output burst_t     burst
);

  byte_t fc_r;
  byte_t serial_r, serial_nxt;
  byte_t sum_r, sum_nxt;
  len_t  left_r, left_nxt;
  logic  in_frame_r, in_frame_nxt;

  len_t               len_fix;
  len_t               len_sat;
  logic [TotalW-1:0]  total;
  byte_t              serial_inc;
  byte_t              b;

  assign in_if.ready = room;
  assign load        = in_if.valid && room;

  always_comb begin
    b          = in_if.payload_byte;
    len_fix    = (in_if.payload_len == '0) ? LenW'(1) : in_if.payload_len;
    len_sat    = (32'(len_fix) > 32'(MaxPayload)) ? LenW'(MaxPayload) : len_fix;
    total      = TotalW'(len_sat) + LenExtra;
    serial_inc = serial_r + 8'd1;

    burst        = '0;
    serial_nxt   = serial_r;
    sum_nxt      = sum_r;
    left_nxt     = left_r;
    in_frame_nxt = in_frame_r;

    if (!in_frame_r) begin
      serial_nxt    = serial_inc;
      sum_nxt       = fc_r + serial_inc + b;
      left_nxt      = len_sat - LenW'(1);
      burst.data[0] = StxByte;
      burst.data[1] = total[15:8];
      burst.data[2] = total[7:0];
      burst.data[3] = fc_r;
      burst.data[4] = serial_inc;
      burst.data[5] = b;
      burst.cnt     = CntHead;
      if (left_nxt == '0) begin
        burst.data[6] = sum_nxt;
        burst.data[7] = CrByte;
        burst.data[8] = LfByte;
        burst.cnt     = CntHeadTail;
      end
    end else begin
      sum_nxt       = sum_r + b;
      left_nxt      = (left_r != '0) ? left_r - LenW'(1) : left_r;
      burst.data[0] = b;
      burst.cnt     = CntMid;
      if (left_nxt == '0) begin
        burst.data[1] = sum_nxt;
        burst.data[2] = CrByte;
        burst.data[3] = LfByte;
        burst.cnt     = CntMidTail;
      end
    end

    burst.tail   = (left_nxt == '0);
    in_frame_nxt = (left_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r       <= FcReset;
      serial_r   <= '0;
      sum_r      <= '0;
      left_r     <= '0;
      in_frame_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fc_r <= cfg_wdata;
      end
      if (load) begin
        serial_r   <= serial_nxt;
        sum_r      <= sum_nxt;
        left_r     <= left_nxt;
        in_frame_r <= in_frame_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  ap_frame_left: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> left_r == '0)
    else $error("idle between frames with bytes still owed");

  ap_serial_step: assert property (@(posedge clk) disable iff (!rst_n)
    load && !in_frame_r |=> serial_r == $past(serial_r) + 8'd1)
    else $error("serial number did not advance on frame start");

  ap_left_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(left_r) < 32'(MaxPayload))
    else $error("remaining byte count above payload limit");
`endif

endmodule

// ===== rtl/sfe_emit.sv =====
module sfe_emit
  import sfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  burst_t     burst,
  output logic       room,
  sfe_out_if.source  out_if
);

  logic [MaxBurst-1:0][ByteW-1:0] data_r;
  logic [CntW-1:0]                cnt_r;
  logic                           tail_r;
  logic                           fire;

  assign fire               = out_if.valid && out_if.ready;
  assign out_if.valid       = (cnt_r != '0);
  assign out_if.out_byte    = data_r[0];
  assign out_if.last_of_run = (cnt_r == CntW'(1));
  assign out_if.frame_done  = tail_r && (cnt_r == CntW'(1));
  assign room               = (cnt_r == '0) || ((cnt_r == CntW'(1)) && out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      tail_r <= 1'b0;
    end else if (load) begin
      cnt_r  <= burst.cnt;
      tail_r <= burst.tail;
    end else if (fire) begin
      cnt_r <= cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= burst.data;
    end else if (fire) begin
      data_r <= {ByteW'(0), data_r[MaxBurst-1:1]};
    end
  end

`ifndef SYNTHESIS
  ap_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MaxBurst)
    else $error("burst count out of range");

  ap_done_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.frame_done |-> out_if.out_byte == LfByte)
    else $error("frame end flagged on a byte other than LF");

  ap_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_if.valid)
    else $error("loaded burst not presented");
`endif

endmodule

// ===== rtl/sum_checked_frame_encoder_unit.sv =====
// Serial framer with length header and additive checksum.
// in_if carries payload bytes; payload_len is sampled only on the first
// byte of a frame (zero is taken as one, values above the payload limit
// saturate). That byte produces 0x7E, the big-endian length plus 3, the
// function code, the incremented serial number and the byte itself; later
// bytes pass through one for one. The final payload byte is followed by
// the 8-bit sum of function code, serial number and payload, then 0x0D 0x0A.
// out_if carries one framed byte per transaction with frame_done on the
// closing 0x0A and last_of_run on the last byte caused by each input.
// cfg_we/cfg_wdata write the function code (reset value 0x04).
// Output bytes are registered; an input's first byte appears in the cycle after it is taken.
// Throughput: one input per cycle while each yields one byte and out_if is
// ready; a longer burst holds in_if.ready low until its last byte leaves
// the output register, which drains one byte per cycle while out_if is ready.
// Reset (synchronous, rst_n low) clears the serial number, the checksum
// and the frame state and drops any pending output bytes.
// A stall on out_if holds the current byte; a new input is taken in the
// cycle the last pending byte leaves.
module sum_checked_frame_encoder_unit
  import sfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  byte_t     cfg_wdata,
  sfe_in_if.sink    in_if,
  sfe_out_if.source out_if
);

  burst_t burst;
  logic   load;
  logic   room;

  sfe_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .room      (room),
    .load      (load),
    .burst     (burst)
  );

  sfe_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .burst  (burst),
    .room   (room),
    .out_if (out_if)
  );

endmodule
